[rtl/core/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, active during reset as well
`define FFTM_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

// clocked check that is switched off while reset is high
`define FFTM_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`endif

[rtl/core/fftm_pkg.sv]
package fftm_pkg;

   // default sizes of the stores
   localparam int DEF_MAX_CELLS   = 1024;
   localparam int DEF_MAX_GROUPS  = 16;
   localparam int DEF_TALLY_WIDTH = 48;

   // field widths
   localparam int OP_W       = 2;
   localparam int CELL_W     = 10;
   localparam int GROUP_W    = 4;
   localparam int ENERGY_W   = 32;
   localparam int SIGMA_W    = 24;
   localparam int CELLS_W    = 11;
   localparam int GROUPS_W   = 5;
   localparam int SCALE_W    = 32;
   localparam int SUM_W      = 64;
   localparam int MOMENTUM_W = 64;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // register reset values
   localparam logic [CELLS_W-1:0]  CELLS_RESET  = CELLS_W'(1024);
   localparam logic [GROUPS_W-1:0] GROUPS_RESET = GROUPS_W'(16);
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1);

   // signed 64-bit limits
   localparam logic [SUM_W-1:0] POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_TALLY   = 2'd0,
      OP_DEPOSIT = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELLS  = 2'd0,
      CSR_GROUPS = 2'd1,
      CSR_SCALE  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TALLY_WB,
      ST_DEP_A,
      ST_DEP_B,
      ST_DEP_C,
      ST_DEP_D,
      ST_DEP_E,
      ST_SCALE_M,
      ST_SCALE_P,
      ST_SCALE_Q,
      ST_SCALE_R
   } state_type;

endpackage

[rtl/core/fftm_ram.sv]
module fftm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/face_flux_tally_momentum_core.sv]
// Tally item: read, then written back in range; an out-of-range tally or unused op is dropped.
// Deposit item: two store reads, shared term multiplier, two saturating adds;
// with last_group the sum is then scaled and shown on rsp_valid, and the next item
// is taken once the result is registered, or later while an earlier result still waits.
// Clear item and synchronous reset: a sweep over (MAX_CELLS+1)*MAX_GROUPS entries (16400
// by default) zeroes both stores with req_ready low; reset also restores the registers.
module face_flux_tally_momentum_core
   import fftm_pkg::*;
#(
   parameter int MAX_CELLS   = DEF_MAX_CELLS,
   parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
   parameter int TALLY_WIDTH = DEF_TALLY_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OP_W-1:0]              req_op,
   input  logic [CELL_W-1:0]            req_cell_req,
   input  logic [GROUP_W-1:0]           req_group,
   input  logic                         req_direction,
   input  logic [ENERGY_W-1:0]          req_energy,
   input  logic [SIGMA_W-1:0]           req_sigma_plus_left,
   input  logic [SIGMA_W-1:0]           req_sigma_minus_right,
   input  logic                         req_last_group,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [CELL_W-1:0]            rsp_cell_index,
   output logic signed [MOMENTUM_W-1:0] rsp_momentum,
   output logic                         rsp_saturated
);

   localparam int DEPTH      = (MAX_CELLS + 1) * MAX_GROUPS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int HALF_W     = (TALLY_WIDTH + 1) / 2;
   localparam int HIGH_W     = TALLY_WIDTH - HALF_W;
   localparam int LO_PROD_W  = HALF_W + SIGMA_W;
   localparam int HI_PROD_W  = HIGH_W + SIGMA_W;
   localparam int PROD_W     = TALLY_WIDTH + SIGMA_W;
   localparam int CMP_W      = (PROD_W > SUM_W) ? PROD_W : SUM_W;
   localparam int CELLS_CAP_VAL  = (MAX_CELLS > 2047) ? 2047 : MAX_CELLS;
   localparam int GROUPS_CAP_VAL = (MAX_GROUPS > 31) ? 31 : MAX_GROUPS;
   localparam logic [CELLS_W-1:0]     CELLS_CAP  = CELLS_W'(CELLS_CAP_VAL);
   localparam logic [GROUPS_W-1:0]    GROUPS_CAP = GROUPS_W'(GROUPS_CAP_VAL);
   localparam logic [ADDR_W-1:0]      LAST_ADDR  = ADDR_W'(DEPTH - 1);
   localparam logic [TALLY_WIDTH-1:0] TALLY_MAX  = {TALLY_WIDTH{1'b1}};

   // store entry of a face and group
   function automatic logic [ADDR_W-1:0] face_addr(input logic [CELLS_W-1:0] face,
                                                   input logic [GROUP_W-1:0] grp);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(face) * ADDR_W'(MAX_GROUPS);
      return base + ADDR_W'(grp);
   endfunction

   // control state
   state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [CELLS_W-1:0]         cells_ff;
   logic [GROUPS_W-1:0]        groups_ff;
   logic [SCALE_W-1:0]         scale_ff;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic                       sum_sat_ff, sum_sat_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // latched item fields
   logic [CELL_W-1:0]          cell_ff;
   logic [ADDR_W-1:0]          tally_addr_ff, tally_addr_in;
   logic                       tally_dir_ff;
   logic [ENERGY_W-1:0]        energy_ff;
   logic [ADDR_W-1:0]          addr1_ff, addr1_in;
   logic                       rng0_ff, rng0_in;
   logic                       rng1_ff, rng1_in;
   logic [SIGMA_W-1:0]         spl_ff;
   logic [SIGMA_W-1:0]         smr_ff;
   logic                       last_ff;

   // term and scaling datapath
   logic [TALLY_WIDTH-1:0]     mag0_ff, mag0_in;
   logic                       neg0_ff, neg0_in;
   logic [TALLY_WIDTH-1:0]     mag1_ff, mag1_in;
   logic                       neg1_ff, neg1_in;
   logic [LO_PROD_W-1:0]       pp_lo_ff, pp_lo_in;
   logic [HI_PROD_W-1:0]       pp_hi_ff, pp_hi_in;
   logic [SUM_W-1:0]           term_mag_ff, term_mag_in;
   logic                       term_neg_ff, term_neg_in;
   logic                       term_sign_ff, term_sign_in;
   logic [SUM_W-1:0]           smag_ff, smag_in;
   logic                       sneg_ff, sneg_in;
   logic [SUM_W-1:0]           plo_ff, plo_in;
   logic [SUM_W-1:0]           phi_ff, phi_in;
   logic [SUM_W-1:0]           q_ff, q_in;

   // result register
   logic [CELL_W-1:0]          rsp_cell_ff, rsp_cell_in;
   logic signed [MOMENTUM_W-1:0] rsp_momentum_ff, rsp_momentum_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   // store ports
   logic                       right_we, left_we;
   logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
   logic [TALLY_WIDTH-1:0]     ram_wdata;
   logic [TALLY_WIDTH-1:0]     right_rdata, left_rdata;

   // combinational helpers
   logic                       req_xfer;
   logic                       slot_free;
   logic [CELLS_W-1:0]         eff_cells;
   logic [GROUPS_W-1:0]        eff_groups;
   logic [CELLS_W-1:0]         face_lo, face_hi, tally_face;
   logic                       grp_ok, tally_ok;
   logic [ADDR_W-1:0]          dep_addr0;
   logic [TALLY_WIDTH-1:0]     tally_old;
   logic [TALLY_WIDTH:0]       tally_add;
   logic [TALLY_WIDTH-1:0]     tally_wdata;
   logic                       diff_ok, diff_neg;
   logic [TALLY_WIDTH-1:0]     diff_mag;
   logic [TALLY_WIDTH-1:0]     mult_mag;
   logic [SIGMA_W-1:0]         mult_sig;
   logic                       comb_neg;
   logic [CMP_W-1:0]           comb_prod, comb_limit;
   logic                       comb_sat;
   logic [SUM_W-1:0]           comb_mag;
   logic [SUM_W-1:0]           add_operand, add_raw, add_res;
   logic                       add_sat;

   fftm_ram #(.WIDTH(TALLY_WIDTH), .DEPTH(DEPTH)) u_right_store (
      .clock      (clock),
      .write_en   (right_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (right_rdata)
   );

   fftm_ram #(.WIDTH(TALLY_WIDTH), .DEPTH(DEPTH)) u_left_store (
      .clock      (clock),
      .write_en   (left_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (left_rdata)
   );

   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // range checks and addresses of the incoming item
   always_comb begin
      eff_cells  = (cells_ff > CELLS_CAP) ? CELLS_CAP : cells_ff;
      eff_groups = (groups_ff > GROUPS_CAP) ? GROUPS_CAP : groups_ff;
      face_lo    = CELLS_W'(req_cell_req);
      face_hi    = face_lo + CELLS_W'(1);
      tally_face = req_direction ? face_hi : face_lo;
      grp_ok     = GROUPS_W'(req_group) < eff_groups;
      tally_ok   = (face_lo < eff_cells) && grp_ok;
      rng0_in    = (face_lo <= eff_cells) && grp_ok;
      rng1_in    = (face_hi <= eff_cells) && grp_ok;
      tally_addr_in = tally_ok ? face_addr(tally_face, req_group) : '0;
      dep_addr0     = rng0_in ? face_addr(face_lo, req_group) : '0;
      addr1_in      = rng1_in ? face_addr(face_hi, req_group) : '0;
   end

   // saturating tally update
   always_comb begin
      tally_old   = tally_dir_ff ? right_rdata : left_rdata;
      tally_add   = {1'b0, tally_old} + (TALLY_WIDTH+1)'(energy_ff);
      tally_wdata = tally_add[TALLY_WIDTH] ? TALLY_MAX : tally_add[TALLY_WIDTH-1:0];
   end

   // net flux of the face just read
   always_comb begin
      diff_ok  = (state_ff == ST_DEP_A) ? rng0_ff : rng1_ff;
      diff_neg = left_rdata > right_rdata;
      diff_mag = diff_neg ? (left_rdata - right_rdata) : (right_rdata - left_rdata);
      if (!diff_ok) begin
         diff_neg = 1'b0;
         diff_mag = '0;
      end
   end

   // shared term multiplier, split into two partial products
   always_comb begin
      mult_mag = (state_ff == ST_DEP_B) ? mag0_ff : mag1_ff;
      mult_sig = (state_ff == ST_DEP_B) ? spl_ff : smr_ff;
      pp_lo_in = LO_PROD_W'(mult_mag[HALF_W-1:0]) * LO_PROD_W'(mult_sig);
      pp_hi_in = HI_PROD_W'(mult_mag[TALLY_WIDTH-1:HALF_W]) * HI_PROD_W'(mult_sig);
   end

   // combine partial products and clamp to the signed range
   always_comb begin
      comb_neg   = (state_ff == ST_DEP_C) ? neg0_ff : neg1_ff;
      comb_prod  = (CMP_W'(pp_hi_ff) << HALF_W) + CMP_W'(pp_lo_ff);
      comb_limit = comb_neg ? CMP_W'(NEG_LIMIT) : CMP_W'(POS_LIMIT);
      comb_sat   = comb_prod > comb_limit;
      comb_mag   = comb_sat ? comb_limit[SUM_W-1:0] : comb_prod[SUM_W-1:0];
   end

   // saturating add of the held term to the cell sum
   always_comb begin
      add_operand = term_neg_ff ? ~term_mag_ff : term_mag_ff;
      add_raw     = sum_ff + add_operand + SUM_W'(term_neg_ff);
      add_sat     = (sum_ff[SUM_W-1] == term_sign_ff) && (add_raw[SUM_W-1] != sum_ff[SUM_W-1]);
      add_res     = add_sat ? (sum_ff[SUM_W-1] ? NEG_LIMIT : POS_LIMIT) : add_raw;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_op)
                  OP_TALLY:   state_in = tally_ok ? ST_TALLY_WB : ST_IDLE;
                  OP_DEPOSIT: state_in = ST_DEP_A;
                  OP_CLEAR:   state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_TALLY_WB: state_in = ST_IDLE;
         ST_DEP_A:    state_in = ST_DEP_B;
         ST_DEP_B:    state_in = ST_DEP_C;
         ST_DEP_C:    state_in = ST_DEP_D;
         ST_DEP_D:    state_in = ST_DEP_E;
         ST_DEP_E:    state_in = last_ff ? ST_SCALE_M : ST_IDLE;
         ST_SCALE_M:  state_in = ST_SCALE_P;
         ST_SCALE_P:  state_in = ST_SCALE_Q;
         ST_SCALE_Q:  state_in = ST_SCALE_R;
         ST_SCALE_R: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // state outputs: handshake and store ports
   always_comb begin
      req_ready = 1'b0;
      right_we  = 1'b0;
      left_we   = 1'b0;
      ram_waddr = tally_addr_ff;
      ram_wdata = tally_wdata;
      ram_raddr = addr1_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            right_we  = 1'b1;
            left_we   = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_raddr = (req_op == OP_DEPOSIT) ? dep_addr0 : tally_addr_in;
         end
         ST_TALLY_WB: begin
            right_we = tally_dir_ff;
            left_we  = !tally_dir_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_addr_in     = clr_addr_ff;
      sum_in          = sum_ff;
      sum_sat_in      = sum_sat_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      mag0_in         = mag0_ff;
      neg0_in         = neg0_ff;
      mag1_in         = mag1_ff;
      neg1_in         = neg1_ff;
      term_mag_in     = term_mag_ff;
      term_neg_in     = term_neg_ff;
      term_sign_in    = term_sign_ff;
      smag_in         = smag_ff;
      sneg_in         = sneg_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      q_in            = q_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_momentum_in = rsp_momentum_ff;
      rsp_sat_in      = rsp_sat_ff;
      unique case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + ADDR_W'(1);
         ST_IDLE: begin
            clr_addr_in = '0;
         end
         ST_DEP_A: begin
            mag0_in = diff_mag;
            neg0_in = diff_neg;
         end
         ST_DEP_B: begin
            mag1_in = diff_mag;
            neg1_in = diff_neg;
         end
         ST_DEP_C, ST_DEP_D: begin
            term_mag_in  = comb_mag;
            term_neg_in  = comb_neg;
            term_sign_in = comb_neg && (comb_mag != '0);
            sum_sat_in   = sum_sat_ff || comb_sat;
            if (state_ff == ST_DEP_D) begin
               sum_in     = add_res;
               sum_sat_in = sum_sat_ff || comb_sat || add_sat;
            end
         end
         ST_DEP_E: begin
            sum_in     = add_res;
            sum_sat_in = sum_sat_ff || add_sat;
         end
         ST_SCALE_M: begin
            sneg_in = sum_ff[SUM_W-1];
            smag_in = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
         end
         ST_SCALE_P: begin
            plo_in = SUM_W'(smag_ff[31:0]) * SUM_W'(scale_ff);
            phi_in = SUM_W'(smag_ff[SUM_W-1:32]) * SUM_W'(scale_ff);
         end
         ST_SCALE_Q: begin
            // floor for negative sums: round the magnitude up
            q_in = phi_ff + SUM_W'(plo_ff[SUM_W-1:32])
                 + SUM_W'(sneg_ff && (plo_ff[31:0] != '0));
         end
         ST_SCALE_R: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_cell_in     = cell_ff;
               rsp_momentum_in = $signed(sneg_ff ? (SUM_W'(0) - q_ff) : q_ff);
               rsp_sat_in      = sum_sat_ff;
               sum_in          = '0;
               sum_sat_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         sum_ff       <= '0;
         sum_sat_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sum_ff       <= sum_in;
         sum_sat_ff   <= sum_sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff  <= CELLS_RESET;
         groups_ff <= GROUPS_RESET;
         scale_ff  <= SCALE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CELLS:  cells_ff  <= csr_write_data[CELLS_W-1:0];
            CSR_GROUPS: groups_ff <= csr_write_data[GROUPS_W-1:0];
            CSR_SCALE:  scale_ff  <= csr_write_data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // item fields, captured on each input transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cell_ff       <= req_cell_req;
         tally_addr_ff <= tally_addr_in;
         tally_dir_ff  <= req_direction;
         energy_ff     <= req_energy;
         addr1_ff      <= addr1_in;
         rng0_ff       <= rng0_in;
         rng1_ff       <= rng1_in;
         spl_ff        <= req_sigma_plus_left;
         smr_ff        <= req_sigma_minus_right;
         last_ff       <= req_last_group;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      mag0_ff         <= mag0_in;
      neg0_ff         <= neg0_in;
      mag1_ff         <= mag1_in;
      neg1_ff         <= neg1_in;
      pp_lo_ff        <= pp_lo_in;
      pp_hi_ff        <= pp_hi_in;
      term_mag_ff     <= term_mag_in;
      term_neg_ff     <= term_neg_in;
      term_sign_ff    <= term_sign_in;
      smag_ff         <= smag_in;
      sneg_ff         <= sneg_in;
      plo_ff          <= plo_in;
      phi_ff          <= phi_in;
      q_ff            <= q_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_momentum_ff <= rsp_momentum_in;
      rsp_sat_ff      <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_cell_ff;
   assign rsp_momentum   = rsp_momentum_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

[rtl/core/fftm_checker.sv]
`include "assert_macros.svh"

module fftm_checker
   import fftm_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         csr_write_en,
   input logic [CSR_INDEX_W-1:0]       csr_index,
   input logic [CSR_DATA_W-1:0]        csr_write_data,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [OP_W-1:0]              req_op,
   input logic [CELL_W-1:0]            req_cell_req,
   input logic [GROUP_W-1:0]           req_group,
   input logic                         req_direction,
   input logic [ENERGY_W-1:0]          req_energy,
   input logic [SIGMA_W-1:0]           req_sigma_plus_left,
   input logic [SIGMA_W-1:0]           req_sigma_minus_right,
   input logic                         req_last_group,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [CELL_W-1:0]            rsp_cell_index,
   input logic signed [MOMENTUM_W-1:0] rsp_momentum,
   input logic                         rsp_saturated
);

   // reset starts the clearing sweep, so no item is taken right after it
   `FFTM_ASSERT(a_reset_sweep, clock, reset |=> !req_ready)

   // reset drops any pending result
   `FFTM_ASSERT(a_reset_rsp, clock, reset |=> !rsp_valid)

   // a clear transfer starts the sweep at once
   `FFTM_ASSERT_RST(a_clear_busy, clock, reset, req_valid && req_ready && req_op == OP_CLEAR |=> !req_ready)

   // a deposit occupies the sequencer in the next cycle
   `FFTM_ASSERT_RST(a_deposit_busy, clock, reset, req_valid && req_ready && req_op == OP_DEPOSIT |=> !req_ready)

   // a stalled result holds its payload
   `FFTM_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_momentum) && $stable(rsp_cell_index) && $stable(rsp_saturated))

endmodule

bind face_flux_tally_momentum_core fftm_checker u_fftm_checker (.*);
